// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the controller and top-level RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define EDF_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define EDF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define EDF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/edf_pkg.sv -----
package edf_pkg;

  localparam int TASK_COUNT_DEF = 8;
  localparam int TIME_BITS_DEF  = 32;
  localparam int IDX_BITS       = 3;
  localparam int MASK_BITS      = 8;
  localparam int DEADLINE_BITS  = 31;
  localparam int WCET_BITS      = 31;
  localparam int NOW_BITS       = 32;

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_SCHED = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CALC,
    ST_UPDT,
    ST_SEL_GO,
    ST_SEL_WAIT,
    ST_PREP,
    ST_SLK_GO,
    ST_SLK_WAIT,
    ST_DONE
  } ctrl_state_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic load;
    logic update;
    logic any_dead;
  } cmd_t;

  // Control part of the token that walks down the cell chain.
  typedef struct packed {
    logic valid;
    logic slack_pass;
    logic found;
    logic high;
  } tok_ctl_t;

  // Signed width that holds wcet + wcet - consumed - remaining exactly.
  function automatic int slack_bits(input int tb);
    return ((tb > WCET_BITS + 1) ? tb : WCET_BITS + 1) + 3;
  endfunction

endpackage

// ----- hdl/edf_if.sv -----
interface edf_in_if;
  logic                               valid;
  logic                               ready;
  logic                               operation;
  logic [edf_pkg::IDX_BITS-1:0]       task_index;
  logic [edf_pkg::DEADLINE_BITS-1:0]  deadline_us;
  logic [edf_pkg::WCET_BITS-1:0]      wcet_us;
  logic [edf_pkg::NOW_BITS-1:0]       now_us;
  logic [edf_pkg::MASK_BITS-1:0]      alive_mask;

  modport source (
    output valid, operation, task_index, deadline_us, wcet_us, now_us, alive_mask,
    input  ready
  );
  modport sink (
    input  valid, operation, task_index, deadline_us, wcet_us, now_us, alive_mask,
    output ready
  );
endinterface

interface edf_out_if;
  logic                          valid;
  logic                          ready;
  logic [edf_pkg::IDX_BITS-1:0]  chosen_task;
  logic                          high_frequency;

  modport source (
    output valid, chosen_task, high_frequency,
    input  ready
  );
  modport sink (
    input  valid, chosen_task, high_frequency,
    output ready
  );
endinterface

// ----- hdl/edf_cell.sv -----
module edf_cell #(
  parameter int TASK_COUNT = edf_pkg::TASK_COUNT_DEF,
  parameter int TIME_BITS  = edf_pkg::TIME_BITS_DEF,
  parameter int CELL_IDX   = 0
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  edf_pkg::cmd_t                      cmd,
  input  logic [edf_pkg::IDX_BITS-1:0]       ld_idx,
  input  logic [edf_pkg::DEADLINE_BITS-1:0]  ld_deadline,
  input  logic [edf_pkg::WCET_BITS-1:0]      ld_wcet,
  input  logic [TIME_BITS-1:0]               elapsed,
  input  logic [$clog2(TASK_COUNT)-1:0]      prev,
  input  logic                               alive,
  input  edf_pkg::tok_ctl_t                  in_ctl,
  input  logic [TIME_BITS-1:0]               in_rem,
  input  logic [$clog2(TASK_COUNT)-1:0]      in_idx,
  input  logic [edf_pkg::WCET_BITS-1:0]      in_wcet,
  input  logic [TIME_BITS-1:0]               in_cons,
  input  logic [edf_pkg::slack_bits(TIME_BITS)-1:0] in_k,
  output edf_pkg::tok_ctl_t                  out_ctl,
  output logic [TIME_BITS-1:0]               out_rem,
  output logic [$clog2(TASK_COUNT)-1:0]      out_idx,
  output logic [edf_pkg::WCET_BITS-1:0]      out_wcet,
  output logic [TIME_BITS-1:0]               out_cons,
  output logic [edf_pkg::slack_bits(TIME_BITS)-1:0] out_k
);

  localparam int TB = TIME_BITS;
  localparam int IW = $clog2(TASK_COUNT);
  localparam int SW = edf_pkg::slack_bits(TIME_BITS);
  localparam int DW = edf_pkg::DEADLINE_BITS;
  localparam int WW = edf_pkg::WCET_BITS;
  localparam int XB = edf_pkg::IDX_BITS;
  localparam bit IS_FIRST = (CELL_IDX == 0);
  localparam bit LOADABLE = (CELL_IDX < (2 ** XB));

  logic [DW-1:0] rel_r, rel_nxt;
  logic [WW-1:0] wcet_r, wcet_nxt;
  logic [TB-1:0] rem_r, rem_nxt;
  logic [TB-1:0] cons_r, cons_nxt;

  edf_pkg::tok_ctl_t ctl_r, ctl_nxt;
  logic [TB-1:0] best_rem_r, best_rem_nxt;
  logic [IW-1:0] best_idx_r, best_idx_nxt;
  logic [WW-1:0] best_wcet_r, best_wcet_nxt;
  logic [TB-1:0] best_cons_r, best_cons_nxt;
  logic [SW-1:0] k_r;

  logic          load_hit;
  logic          is_prev;
  logic [TB+1:0] diff;
  logic          diff_ovf;
  logic [TB-1:0] rem_sub;
  logic [TB-1:0] cons_base;
  logic [TB:0]   cons_sum;
  logic [TB-1:0] cons_add;
  logic          own_less;
  logic          take;
  logic [SW-1:0] own_margin;
  logic [SW-1:0] dead_sum;
  logic          fail;

  assign load_hit = cmd.load && LOADABLE && (ld_idx == XB'(CELL_IDX));
  assign is_prev  = (prev == IW'(CELL_IDX));

  // Saturating subtract: clamp at the most negative value.
  assign diff     = {{2{rem_r[TB-1]}}, rem_r} - {2'b00, elapsed};
  assign diff_ovf = (diff[TB+1:TB-1] != 3'b000) && (diff[TB+1:TB-1] != 3'b111);
  assign rem_sub  = diff_ovf ? {1'b1, {(TB-1){1'b0}}} : diff[TB-1:0];

  // Saturating add onto the previous selection's consumed time, or onto zero when any task is dead.
  assign cons_base = cmd.any_dead ? '0 : cons_r;
  assign cons_sum  = {1'b0, cons_base} + {1'b0, elapsed};
  assign cons_add  = cons_sum[TB] ? '1 : cons_sum[TB-1:0];

  always_comb begin
    rel_nxt  = rel_r;
    wcet_nxt = wcet_r;
    rem_nxt  = rem_r;
    cons_nxt = cons_r;
    if (load_hit) begin
      rel_nxt  = ld_deadline;
      wcet_nxt = ld_wcet;
      rem_nxt  = TB'(ld_deadline);
    end else if (cmd.update) begin
      rem_nxt = alive ? rem_sub : TB'(rel_r);
      if (is_prev) begin
        cons_nxt = cons_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rel_r  <= '0;
      wcet_r <= '0;
      rem_r  <= '0;
      cons_r <= '0;
    end else begin
      rel_r  <= rel_nxt;
      wcet_r <= wcet_nxt;
      rem_r  <= rem_nxt;
      cons_r <= cons_nxt;
    end
  end

  // Selection pass: keep the smaller remaining deadline, earlier cell wins ties.
  // Cell 0 always loads its data into an empty token so that "none alive" picks it.
  assign own_less = $signed(rem_r) < $signed(in_rem);
  assign take     = !in_ctl.slack_pass &&
                    (in_ctl.found ? (alive && own_less) : (alive || IS_FIRST));

  // Slack pass: a non-negative margin, or for a dead cell a non-negative wcet + k, means the check fails.
  assign own_margin = {{(SW-WW){1'b0}}, wcet_r} - {{(SW-TB){1'b0}}, cons_r}
                    - {{(SW-TB){rem_r[TB-1]}}, rem_r};
  assign dead_sum   = {{(SW-WW){1'b0}}, wcet_r} + in_k;
  assign fail       = alive ? !own_margin[SW-1] : !dead_sum[SW-1];

  always_comb begin
    ctl_nxt       = in_ctl;
    ctl_nxt.found = in_ctl.found | (alive & !in_ctl.slack_pass);
    ctl_nxt.high  = in_ctl.high | (in_ctl.slack_pass & fail);
    best_rem_nxt  = take ? rem_r : in_rem;
    best_idx_nxt  = take ? IW'(CELL_IDX) : in_idx;
    best_wcet_nxt = take ? wcet_r : in_wcet;
    best_cons_nxt = take ? cons_r : in_cons;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ctl.valid) begin
      best_rem_r  <= best_rem_nxt;
      best_idx_r  <= best_idx_nxt;
      best_wcet_r <= best_wcet_nxt;
      best_cons_r <= best_cons_nxt;
      k_r         <= in_k;
    end
  end

  assign out_ctl  = ctl_r;
  assign out_rem  = best_rem_r;
  assign out_idx  = best_idx_r;
  assign out_wcet = best_wcet_r;
  assign out_cons = best_cons_r;
  assign out_k    = k_r;

endmodule

// ----- hdl/edf_ctrl.sv -----
`include "assert_macros.svh"

module edf_ctrl #(
  parameter int TASK_COUNT = edf_pkg::TASK_COUNT_DEF,
  parameter int TIME_BITS  = edf_pkg::TIME_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  edf_in_if.sink                             in_chan,
  edf_out_if.source                          out_chan,
  output edf_pkg::cmd_t                      cmd,
  output logic [edf_pkg::IDX_BITS-1:0]       ld_idx,
  output logic [edf_pkg::DEADLINE_BITS-1:0]  ld_deadline,
  output logic [edf_pkg::WCET_BITS-1:0]      ld_wcet,
  output logic [TIME_BITS-1:0]               elapsed,
  output logic [$clog2(TASK_COUNT)-1:0]      prev,
  output logic [TASK_COUNT-1:0]              alive,
  output edf_pkg::tok_ctl_t                  head_ctl,
  output logic [TIME_BITS-1:0]               head_rem,
  output logic [$clog2(TASK_COUNT)-1:0]      head_idx,
  output logic [edf_pkg::WCET_BITS-1:0]      head_wcet,
  output logic [TIME_BITS-1:0]               head_cons,
  output logic [edf_pkg::slack_bits(TIME_BITS)-1:0] head_k,
  input  edf_pkg::tok_ctl_t                  tail_ctl,
  input  logic [TIME_BITS-1:0]               tail_rem,
  input  logic [$clog2(TASK_COUNT)-1:0]      tail_idx,
  input  logic [edf_pkg::WCET_BITS-1:0]      tail_wcet,
  input  logic [TIME_BITS-1:0]               tail_cons,
  input  logic [edf_pkg::slack_bits(TIME_BITS)-1:0] tail_k
);

  localparam int TB = TIME_BITS;
  localparam int IW = $clog2(TASK_COUNT);
  localparam int SW = edf_pkg::slack_bits(TIME_BITS);
  localparam int WW = edf_pkg::WCET_BITS;
  localparam int XB = edf_pkg::IDX_BITS;
  localparam int MB = edf_pkg::MASK_BITS;

  edf_pkg::ctrl_state_t state_r, state_nxt;

  logic [XB-1:0]                     idx_r;
  logic [edf_pkg::DEADLINE_BITS-1:0] dl_r;
  logic [WW-1:0]                     wc_r;
  logic [TB-1:0]                     now_r;
  logic [MB-1:0]                     mask_r;
  logic [TB-1:0]                     elapsed_r;
  logic [TB-1:0]                     last_time_r;
  logic [XB-1:0]                     last_sel_r;
  logic [IW-1:0]                     sel_idx_r;
  logic [TB-1:0]                     sel_rem_r;
  logic [WW-1:0]                     sel_wcet_r;
  logic [TB-1:0]                     sel_cons_r;
  logic [SW-1:0]                     k_r;
  logic                              high_r;
  logic                              out_valid_r;
  logic [XB-1:0]                     chosen_r;
  logic                              highf_r;

  logic accept;
  logic in_ready;
  logic out_load;
  logic go_sel;
  logic go_slk;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= edf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    go_sel    = 1'b0;
    go_slk    = 1'b0;
    case (state_r)
      edf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_chan.valid) begin
          state_nxt = (in_chan.operation == edf_pkg::OP_SCHED) ? edf_pkg::ST_CALC
                                                               : edf_pkg::ST_LOAD;
        end
      end
      edf_pkg::ST_LOAD:   state_nxt = edf_pkg::ST_IDLE;
      edf_pkg::ST_CALC:   state_nxt = edf_pkg::ST_UPDT;
      edf_pkg::ST_UPDT:   state_nxt = edf_pkg::ST_SEL_GO;
      edf_pkg::ST_SEL_GO: begin
        go_sel    = 1'b1;
        state_nxt = edf_pkg::ST_SEL_WAIT;
      end
      edf_pkg::ST_SEL_WAIT: begin
        if (tail_ctl.valid) begin
          state_nxt = edf_pkg::ST_PREP;
        end
      end
      edf_pkg::ST_PREP:   state_nxt = edf_pkg::ST_SLK_GO;
      edf_pkg::ST_SLK_GO: begin
        go_slk    = 1'b1;
        state_nxt = edf_pkg::ST_SLK_WAIT;
      end
      edf_pkg::ST_SLK_WAIT: begin
        if (tail_ctl.valid) begin
          state_nxt = edf_pkg::ST_DONE;
        end
      end
      edf_pkg::ST_DONE: begin
        // Hold the result until the output register frees up.
        if (!out_valid_r || out_chan.ready) begin
          out_load  = 1'b1;
          state_nxt = edf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = edf_pkg::ST_IDLE;
    endcase
  end

  assign accept        = in_chan.valid && in_ready;
  assign in_chan.ready = in_ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r  <= in_chan.task_index;
      dl_r   <= in_chan.deadline_us;
      wc_r   <= in_chan.wcet_us;
      now_r  <= TB'(in_chan.now_us);
      mask_r <= in_chan.alive_mask;
    end
    if (state_r == edf_pkg::ST_CALC) begin
      elapsed_r <= now_r - last_time_r;
    end
    if (state_r == edf_pkg::ST_SEL_WAIT && tail_ctl.valid) begin
      sel_idx_r  <= tail_idx;
      sel_rem_r  <= tail_rem;
      sel_wcet_r <= tail_wcet;
      sel_cons_r <= tail_cons;
    end
    if (state_r == edf_pkg::ST_PREP) begin
      // wcet[sel] - consumed[sel] - remaining[sel]; dead cells add their own wcet.
      k_r <= {{(SW-WW){1'b0}}, sel_wcet_r} - {{(SW-TB){1'b0}}, sel_cons_r}
           - {{(SW-TB){sel_rem_r[TB-1]}}, sel_rem_r};
    end
    if (state_r == edf_pkg::ST_SLK_WAIT && tail_ctl.valid) begin
      high_r <= tail_ctl.high;
    end
    if (out_load) begin
      chosen_r <= XB'(sel_idx_r);
      highf_r  <= high_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r <= '0;
      last_sel_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == edf_pkg::ST_UPDT) begin
        last_time_r <= now_r;
      end
      if (out_load) begin
        last_sel_r <= XB'(sel_idx_r);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < TASK_COUNT; gi++) begin : g_alive
      if (gi < MB) begin : g_mask
        assign alive[gi] = mask_r[gi];
      end else begin : g_none
        assign alive[gi] = 1'b0;
      end
    end
  endgenerate

  assign cmd.load     = (state_r == edf_pkg::ST_LOAD);
  assign cmd.update   = (state_r == edf_pkg::ST_UPDT);
  assign cmd.any_dead = ~&alive;

  assign ld_idx      = idx_r;
  assign ld_deadline = dl_r;
  assign ld_wcet     = wc_r;
  assign elapsed     = elapsed_r;
  assign prev        = IW'(last_sel_r);

  assign head_ctl.valid      = go_sel | go_slk;
  assign head_ctl.slack_pass = go_slk;
  assign head_ctl.found      = 1'b0;
  assign head_ctl.high       = 1'b0;
  assign head_rem            = '0;
  assign head_idx            = '0;
  assign head_wcet           = '0;
  assign head_cons           = '0;
  assign head_k              = k_r;

  assign out_chan.valid          = out_valid_r;
  assign out_chan.chosen_task    = chosen_r;
  assign out_chan.high_frequency = highf_r;

  `EDF_ASSERT_NXT(a_busy_after_accept, clk, rst_n, accept, !in_chan.ready,
    "edf_ctrl: input taken again right after an accept")
  `EDF_ASSERT_IMP(a_tail_in_wait, clk, rst_n, tail_ctl.valid,
    state_r == edf_pkg::ST_SEL_WAIT || state_r == edf_pkg::ST_SLK_WAIT,
    "edf_ctrl: token left the chain outside a wait state")
  `EDF_ASSERT_IMP(a_tail_phase, clk, rst_n,
    tail_ctl.valid && state_r == edf_pkg::ST_SLK_WAIT, tail_ctl.slack_pass,
    "edf_ctrl: selection token seen while waiting for slack pass")
  `EDF_ASSERT_IMP(a_k_intact, clk, rst_n, tail_ctl.valid && tail_ctl.slack_pass,
    tail_k == k_r, "edf_ctrl: slack term corrupted along the chain")

endmodule

// ----- hdl/edf_task_select_with_dvfs.sv -----
// Earliest-deadline-first task selector with a two-level frequency request.
// Input channel in_chan: one word is either a load (operation 0: task_index,
// deadline_us, wcet_us) or a schedule request (operation 1: now_us, alive_mask).
// Output channel out_chan: one word per schedule request (chosen_task,
// high_frequency); a load gives no output word.
// The task table sits in a row of TASK_COUNT cells. A schedule request updates
// all cells together, then a token walks the row twice, one cell per
// cycle: first to find the earliest deadline, then to run the slack checks.
// A load passes through the load state before the next word is taken; a
// schedule word passes through the calc, update, selection go and wait, prep,
// slack go and wait, and done states before it shows on out_chan, and the next
// input is taken once it has moved into the output register.
// One item is in flight at a time; in_chan.ready is high only when idle.
// A finished result sits in the output register while the next input is taken;
// if the receiver stalls, a second result waits inside the block until the
// register frees up, and no input is taken meanwhile.
// Reset (synchronous, rst_n low) clears the whole task table, the last
// decision time and the last selection; no output word is pending after it.
`include "assert_macros.svh"

module edf_task_select_with_dvfs #(
  parameter int TASK_COUNT = edf_pkg::TASK_COUNT_DEF,
  parameter int TIME_BITS  = edf_pkg::TIME_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  edf_in_if.sink     in_chan,
  edf_out_if.source  out_chan
);

  localparam int TB = TIME_BITS;
  localparam int IW = $clog2(TASK_COUNT);
  localparam int SW = edf_pkg::slack_bits(TIME_BITS);
  localparam int WW = edf_pkg::WCET_BITS;

  edf_pkg::cmd_t                     cmd;
  logic [edf_pkg::IDX_BITS-1:0]      ld_idx;
  logic [edf_pkg::DEADLINE_BITS-1:0] ld_deadline;
  logic [WW-1:0]                     ld_wcet;
  logic [TB-1:0]                     elapsed;
  logic [IW-1:0]                     prev;
  logic [TASK_COUNT-1:0]             alive;

  edf_pkg::tok_ctl_t ctl_w  [TASK_COUNT+1];
  logic [TB-1:0]     rem_w  [TASK_COUNT+1];
  logic [IW-1:0]     idx_w  [TASK_COUNT+1];
  logic [WW-1:0]     wcet_w [TASK_COUNT+1];
  logic [TB-1:0]     cons_w [TASK_COUNT+1];
  logic [SW-1:0]     k_w    [TASK_COUNT+1];

  logic [TASK_COUNT-1:0] tok_valid;

  edf_ctrl #(
    .TASK_COUNT (TASK_COUNT),
    .TIME_BITS  (TIME_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cmd         (cmd),
    .ld_idx      (ld_idx),
    .ld_deadline (ld_deadline),
    .ld_wcet     (ld_wcet),
    .elapsed     (elapsed),
    .prev        (prev),
    .alive       (alive),
    .head_ctl    (ctl_w[0]),
    .head_rem    (rem_w[0]),
    .head_idx    (idx_w[0]),
    .head_wcet   (wcet_w[0]),
    .head_cons   (cons_w[0]),
    .head_k      (k_w[0]),
    .tail_ctl    (ctl_w[TASK_COUNT]),
    .tail_rem    (rem_w[TASK_COUNT]),
    .tail_idx    (idx_w[TASK_COUNT]),
    .tail_wcet   (wcet_w[TASK_COUNT]),
    .tail_cons   (cons_w[TASK_COUNT]),
    .tail_k      (k_w[TASK_COUNT])
  );

  genvar gi;
  generate
    for (gi = 0; gi < TASK_COUNT; gi++) begin : g_cell
      edf_cell #(
        .TASK_COUNT (TASK_COUNT),
        .TIME_BITS  (TIME_BITS),
        .CELL_IDX   (gi)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .ld_idx      (ld_idx),
        .ld_deadline (ld_deadline),
        .ld_wcet     (ld_wcet),
        .elapsed     (elapsed),
        .prev        (prev),
        .alive       (alive[gi]),
        .in_ctl      (ctl_w[gi]),
        .in_rem      (rem_w[gi]),
        .in_idx      (idx_w[gi]),
        .in_wcet     (wcet_w[gi]),
        .in_cons     (cons_w[gi]),
        .in_k        (k_w[gi]),
        .out_ctl     (ctl_w[gi+1]),
        .out_rem     (rem_w[gi+1]),
        .out_idx     (idx_w[gi+1]),
        .out_wcet    (wcet_w[gi+1]),
        .out_cons    (cons_w[gi+1]),
        .out_k       (k_w[gi+1])
      );
      assign tok_valid[gi] = ctl_w[gi+1].valid;
    end
  endgenerate

  `EDF_ASSERT_ALWAYS(a_single_token, clk, rst_n, $onehot0(tok_valid),
    "edf_task_select_with_dvfs: more than one token in the cell row")

endmodule
